// ----- sv/lrpe_pkg.sv -----
// ----------------------------------------------------------------------------
// lrpe_pkg
// Types, codes and the control store of the LR shift-reduce parse engine.
// ----------------------------------------------------------------------------
`default_nettype none

package lrpe_pkg;

  // input item
  typedef struct packed {
    logic [1:0] func;
    logic [5:0] state_index;
    logic [3:0] terminal_id;
    logic [3:0] nonterminal_id;
    logic [1:0] action_kind;
    logic [5:0] action_target;
    logic [5:0] goto_state;
    logic       goto_valid;
    logic [4:0] production_index;
    logic [3:0] rhs_length;
    logic [3:0] lhs_id;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [2:0] event_res;
    logic [5:0] event_value;
    logic [5:0] top_state;
    logic [5:0] depth;
    logic       last;
  } res_item_t;

  // item function codes
  localparam logic [1:0] FN_ACTION = 2'd0;
  localparam logic [1:0] FN_GOTO   = 2'd1;
  localparam logic [1:0] FN_PROD   = 2'd2;
  localparam logic [1:0] FN_PARSE  = 2'd3;

  // action kinds
  localparam logic [1:0] K_ERR    = 2'd0;
  localparam logic [1:0] K_SHIFT  = 2'd1;
  localparam logic [1:0] K_REDUCE = 2'd2;
  localparam logic [1:0] K_ACCEPT = 2'd3;

  // result event codes
  localparam logic [2:0] EV_LOAD   = 3'd0;
  localparam logic [2:0] EV_SHIFT  = 3'd1;
  localparam logic [2:0] EV_REDUCE = 3'd2;
  localparam logic [2:0] EV_ACCEPT = 3'd3;
  localparam logic [2:0] EV_ERROR  = 3'd4;

  // reductions allowed per token before the next one is an error
  localparam logic [5:0] REDUCE_LIMIT = 6'd33;

  // datapath operations
  typedef enum logic [3:0] {
    OP_FETCH = 4'd0,
    OP_LOAD  = 4'd1,
    OP_ACT   = 4'd2,
    OP_DEC   = 4'd3,
    OP_SHIFT = 4'd4,
    OP_RED1  = 4'd5,
    OP_RED2  = 4'd6,
    OP_RED3  = 4'd7,
    OP_RED4  = 4'd8,
    OP_FAIL  = 4'd9,
    OP_ACC   = 4'd10
  } op_t;

  // branch modes
  typedef enum logic [1:0] {
    BR_NEXT  = 2'd0,
    BR_CHECK = 2'd1,
    BR_FUNC  = 2'd2,
    BR_KIND  = 2'd3
  } br_t;

  // step addresses
  typedef logic [3:0] step_t;
  localparam step_t ST_FETCH = 4'd0;
  localparam step_t ST_LOAD  = 4'd1;
  localparam step_t ST_ACT   = 4'd2;
  localparam step_t ST_DEC   = 4'd3;
  localparam step_t ST_SHIFT = 4'd4;
  localparam step_t ST_RED1  = 4'd5;
  localparam step_t ST_RED2  = 4'd6;
  localparam step_t ST_RED3  = 4'd7;
  localparam step_t ST_RED4  = 4'd8;
  localparam step_t ST_FAIL  = 4'd9;
  localparam step_t ST_ACC   = 4'd10;

  // one control word
  typedef struct packed {
    op_t   op;
    br_t   br;
    logic  wait_in;
    logic  wait_out;
    logic  last;
    step_t nxt;
  } ucode_t;

  // sequencer -> datapath
  typedef struct packed {
    op_t  op;
    logic fire;
    logic last;
  } dp_ctrl_t;

  // datapath -> sequencer
  typedef struct packed {
    logic       fail;
    logic [1:0] kind;
    logic [1:0] func;
    logic       out_free;
  } dp_status_t;

  // control store
  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    case (step)
      ST_FETCH: w = '{OP_FETCH, BR_FUNC,  1'b1, 1'b0, 1'b0, ST_FETCH};
      ST_LOAD:  w = '{OP_LOAD,  BR_NEXT,  1'b0, 1'b1, 1'b1, ST_FETCH};
      ST_ACT:   w = '{OP_ACT,   BR_NEXT,  1'b0, 1'b0, 1'b0, ST_DEC};
      ST_DEC:   w = '{OP_DEC,   BR_KIND,  1'b0, 1'b0, 1'b0, ST_FETCH};
      ST_SHIFT: w = '{OP_SHIFT, BR_CHECK, 1'b0, 1'b1, 1'b1, ST_FETCH};
      ST_RED1:  w = '{OP_RED1,  BR_CHECK, 1'b0, 1'b0, 1'b0, ST_RED2};
      ST_RED2:  w = '{OP_RED2,  BR_CHECK, 1'b0, 1'b0, 1'b0, ST_RED3};
      ST_RED3:  w = '{OP_RED3,  BR_NEXT,  1'b0, 1'b0, 1'b0, ST_RED4};
      ST_RED4:  w = '{OP_RED4,  BR_CHECK, 1'b0, 1'b1, 1'b0, ST_ACT};
      ST_FAIL:  w = '{OP_FAIL,  BR_NEXT,  1'b0, 1'b1, 1'b1, ST_FETCH};
      ST_ACC:   w = '{OP_ACC,   BR_NEXT,  1'b0, 1'b1, 1'b1, ST_FETCH};
      default:  w = '{OP_FETCH, BR_NEXT,  1'b0, 1'b0, 1'b0, ST_FETCH};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- sv/lrpe_useq.sv -----
// ----------------------------------------------------------------------------
// lrpe_useq
// Step counter and control store: issues one control word per step.
// ----------------------------------------------------------------------------
`default_nettype none

module lrpe_useq (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  input  lrpe_pkg::dp_status_t    status,
  output lrpe_pkg::dp_ctrl_t      ctrl
);
  import lrpe_pkg::*;

  step_t  step_r;
  step_t  step_nxt;
  ucode_t uw;
  logic   fire;
  step_t  target;

  assign uw = ucode_rom(step_r);

  always_comb begin
    if (uw.wait_in) begin
      fire = in_valid;
    end else if (uw.wait_out) begin
      fire = status.out_free;
    end else begin
      fire = 1'b1;
    end
  end

  always_comb begin
    case (uw.br)
      BR_NEXT:  target = uw.nxt;
      BR_CHECK: target = status.fail ? ST_FAIL : uw.nxt;
      BR_FUNC:  target = (status.func == FN_PARSE) ? ST_ACT : ST_LOAD;
      BR_KIND: begin
        case (status.kind)
          K_SHIFT:  target = ST_SHIFT;
          K_REDUCE: target = ST_RED1;
          K_ACCEPT: target = ST_ACC;
          default:  target = ST_FAIL;
        endcase
      end
      default:  target = ST_FETCH;
    endcase
  end

  assign step_nxt = fire ? target : step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_FETCH;
    end else begin
      step_r <= step_nxt;
    end
  end

  assign ctrl.op   = uw.op;
  assign ctrl.fire = fire;
  assign ctrl.last = uw.last;

endmodule

`default_nettype wire

// ----- sv/lrpe_dpath.sv -----
// ----------------------------------------------------------------------------
// lrpe_dpath
// Parse tables, state stack and result register, driven by control words.
// ----------------------------------------------------------------------------
`default_nettype none

module lrpe_dpath #(
  parameter int NUM_STATES       = 64,
  parameter int NUM_TERMINALS    = 16,
  parameter int NUM_NONTERMINALS = 16,
  parameter int NUM_PRODUCTIONS  = 32,
  parameter int STACK_DEPTH      = 32
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  lrpe_pkg::in_item_t      in_data,
  input  lrpe_pkg::dp_ctrl_t      ctrl,
  output lrpe_pkg::dp_status_t    status,
  output logic                    out_valid,
  input  wire                     out_stall,
  output lrpe_pkg::res_item_t     out_data
);
  import lrpe_pkg::*;

  localparam int ADEPTH = NUM_STATES * NUM_TERMINALS;
  localparam int GDEPTH = NUM_STATES * NUM_NONTERMINALS;
  localparam int AAW    = $clog2(ADEPTH);
  localparam int GAW    = $clog2(GDEPTH);
  localparam int PAW    = (NUM_PRODUCTIONS > 1) ? $clog2(NUM_PRODUCTIONS) : 1;
  localparam int SIW    = $clog2(STACK_DEPTH);
  localparam int SPW    = $clog2(STACK_DEPTH + 1);

  // stores
  logic [7:0] act_mem  [ADEPTH];
  logic [6:0] goto_mem [GDEPTH];
  logic [7:0] prod_mem [NUM_PRODUCTIONS];
  logic [5:0] stk_mem  [STACK_DEPTH];

  in_item_t       in_r;
  logic [SPW-1:0] sp_r, sp_nxt;
  logic [5:0]     top_r, top_nxt;
  logic [5:0]     cnt_r;
  logic [7:0]     act_rd_r;
  logic           act_ok_r;
  logic [7:0]     prod_rd_r;
  logic [5:0]     stk_rd_r;
  logic           stk_zero_r;
  logic [6:0]     goto_rd_r;
  logic           g_ok_r;
  logic [SPW-1:0] base_r;
  logic [3:0]     lhs_r;
  logic           out_valid_r;
  res_item_t      out_r;

  logic [5:0]     tgt;
  logic [3:0]     len;
  logic [3:0]     lhs;
  logic [SPW-1:0] base_c;
  logic [SPW-1:0] base_m1;
  logic [5:0]     top2;
  logic           fail;
  logic           out_free;
  logic           commit;
  logic [AAW-1:0] act_wr_addr, act_rd_addr;
  logic [GAW-1:0] goto_wr_addr, goto_rd_addr;
  logic [2:0]     ev;
  logic [5:0]     ev_val;

  assign tgt     = act_rd_r[5:0];
  assign len     = prod_rd_r[7:4];
  assign lhs     = prod_rd_r[3:0];
  assign base_c  = sp_r - SPW'(len);
  assign base_m1 = base_c - SPW'(1);
  assign top2    = stk_zero_r ? 6'd0 : stk_rd_r;

  assign act_wr_addr  = AAW'(in_r.state_index) * AAW'(NUM_TERMINALS) +
                        AAW'(in_r.terminal_id);
  assign act_rd_addr  = AAW'(top_r) * AAW'(NUM_TERMINALS) + AAW'(in_r.terminal_id);
  assign goto_wr_addr = GAW'(in_r.state_index) * GAW'(NUM_NONTERMINALS) +
                        GAW'(in_r.nonterminal_id);
  assign goto_rd_addr = GAW'(top2) * GAW'(NUM_NONTERMINALS) + GAW'(lhs_r);

  // failure checks of the checking steps
  always_comb begin
    case (ctrl.op)
      OP_SHIFT: fail = 32'(sp_r) >= STACK_DEPTH;
      OP_RED1:  fail = (cnt_r >= REDUCE_LIMIT) || (32'(tgt) >= NUM_PRODUCTIONS);
      OP_RED2:  fail = (32'(len) >= 32'(sp_r)) || (32'(lhs) >= NUM_NONTERMINALS) ||
                       ((32'(sp_r) - 32'(len)) >= STACK_DEPTH);
      OP_RED4:  fail = !goto_rd_r[6] || !g_ok_r;
      default:  fail = 1'b0;
    endcase
  end

  assign out_free = !out_valid_r || !out_stall;
  assign commit   = ctrl.fire && !fail;

  assign status.fail     = fail;
  assign status.kind     = act_ok_r ? act_rd_r[7:6] : K_ERR;
  assign status.func     = in_data.func;
  assign status.out_free = out_free;

  // next stack pointer, top and event
  always_comb begin
    sp_nxt  = sp_r;
    top_nxt = top_r;
    ev      = EV_LOAD;
    ev_val  = 6'd0;
    case (ctrl.op)
      OP_SHIFT: begin
        sp_nxt  = sp_r + SPW'(1);
        top_nxt = tgt;
        ev      = EV_SHIFT;
        ev_val  = tgt;
      end
      OP_RED4: begin
        sp_nxt  = base_r + SPW'(1);
        top_nxt = goto_rd_r[5:0];
        ev      = EV_REDUCE;
        ev_val  = tgt;
      end
      OP_FAIL: begin
        sp_nxt  = SPW'(1);
        top_nxt = 6'd0;
        ev      = EV_ERROR;
      end
      OP_ACC: begin
        sp_nxt  = SPW'(1);
        top_nxt = 6'd0;
        ev      = EV_ACCEPT;
      end
      default: begin
        sp_nxt  = sp_r;
        top_nxt = top_r;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r        <= SPW'(1);
      top_r       <= 6'd0;
      cnt_r       <= 6'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (commit) begin
        sp_r  <= sp_nxt;
        top_r <= top_nxt;
      end
      if (ctrl.fire && ctrl.op == OP_FETCH) begin
        cnt_r <= 6'd0;
      end else if (commit && ctrl.op == OP_RED4) begin
        cnt_r <= cnt_r + 6'd1;
      end
      if (commit && (ctrl.op == OP_LOAD || ctrl.op == OP_SHIFT || ctrl.op == OP_RED4 ||
                     ctrl.op == OP_FAIL || ctrl.op == OP_ACC)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctrl.fire && ctrl.op == OP_FETCH) begin
      in_r <= in_data;
    end
    if (ctrl.op == OP_ACT) begin
      act_ok_r <= (32'(in_r.terminal_id) < NUM_TERMINALS) && (32'(top_r) < NUM_STATES);
    end
    if (ctrl.op == OP_RED2) begin
      base_r     <= base_c;
      lhs_r      <= lhs;
      stk_zero_r <= (base_m1 == '0);
    end
    if (ctrl.op == OP_RED3) begin
      g_ok_r <= 32'(top2) < NUM_STATES;
    end
    if (commit && (ctrl.op == OP_LOAD || ctrl.op == OP_SHIFT || ctrl.op == OP_RED4 ||
                   ctrl.op == OP_FAIL || ctrl.op == OP_ACC)) begin
      out_r.event_res   <= ev;
      out_r.event_value <= ev_val;
      out_r.top_state   <= top_nxt;
      out_r.depth       <= 6'(sp_nxt);
      out_r.last        <= ctrl.last;
    end
  end

  // action table
  always_ff @(posedge clk) begin
    if (commit && ctrl.op == OP_LOAD && in_r.func == FN_ACTION &&
        32'(in_r.state_index) < NUM_STATES && 32'(in_r.terminal_id) < NUM_TERMINALS) begin
      act_mem[act_wr_addr] <= {in_r.action_kind, in_r.action_target};
    end
    if (ctrl.op == OP_ACT) begin
      act_rd_r <= act_mem[act_rd_addr];
    end
  end

  // goto table
  always_ff @(posedge clk) begin
    if (commit && ctrl.op == OP_LOAD && in_r.func == FN_GOTO &&
        32'(in_r.state_index) < NUM_STATES &&
        32'(in_r.nonterminal_id) < NUM_NONTERMINALS) begin
      goto_mem[goto_wr_addr] <= {in_r.goto_valid, in_r.goto_state};
    end
    if (ctrl.op == OP_RED3) begin
      goto_rd_r <= goto_mem[goto_rd_addr];
    end
  end

  // production table
  always_ff @(posedge clk) begin
    if (commit && ctrl.op == OP_LOAD && in_r.func == FN_PROD &&
        32'(in_r.production_index) < NUM_PRODUCTIONS) begin
      prod_mem[PAW'(in_r.production_index)] <= {in_r.rhs_length, in_r.lhs_id};
    end
    if (ctrl.op == OP_RED1 && 32'(tgt) < NUM_PRODUCTIONS) begin
      prod_rd_r <= prod_mem[PAW'(tgt)];
    end
  end

  // state stack; entry zero is never written and reads as state 0
  always_ff @(posedge clk) begin
    if (commit && ctrl.op == OP_SHIFT) begin
      stk_mem[SIW'(sp_r)] <= tgt;
    end else if (commit && ctrl.op == OP_RED4) begin
      stk_mem[SIW'(base_r)] <= goto_rd_r[5:0];
    end
    if (ctrl.op == OP_RED2) begin
      stk_rd_r <= stk_mem[SIW'(base_m1)];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ----- sv/lr_shift_reduce_parse_engine_core.sv -----
// ----------------------------------------------------------------------------
// lr_shift_reduce_parse_engine_core
// Table-driven LR shift-reduce parse engine run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// Usage: load items (func 0/1/2) fill the action, goto and production tables;
// each answers one "load done" result. Parse items (func 3) carry a terminal
// id; each yields zero or more reduce results and then one shift, accept or
// error result, the final one flagged with last.
// Channels: in_valid/in_stall/in_data and out_valid/out_stall/out_data; an
// item moves on an edge with valid high and stall low.
// Steps: a load runs fetch and load; a shift, accept or error action runs fetch,
// table read, decode and act. Each reduction adds production read, stack
// read, goto read, push, then the action read and decode again; an error
// caught by a check step adds the error step. The steps follow from the
// registered reads of the table and stack memories.
// The output register holds one result; a stalled receiver freezes the
// sequencer at its next emitting step, and the input is taken only in the
// fetch step, so one item is in work at a time.
// Reset: stack holds state 0 with depth 1. The tables are not cleared: a
// parse that reads an entry never loaded gives undefined results.
// ----------------------------------------------------------------------------
`default_nettype none

module lr_shift_reduce_parse_engine_core #(
  parameter int NUM_STATES       = 64,
  parameter int NUM_TERMINALS    = 16,
  parameter int NUM_NONTERMINALS = 16,
  parameter int NUM_PRODUCTIONS  = 32,
  parameter int STACK_DEPTH      = 32
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  lrpe_pkg::in_item_t      in_data,
  output logic                    out_valid,
  input  wire                     out_stall,
  output lrpe_pkg::res_item_t     out_data
);
  import lrpe_pkg::*;

  dp_ctrl_t   ctrl;
  dp_status_t status;

  // input is taken only while the sequencer sits in its fetch step
  assign in_stall = (ctrl.op != OP_FETCH);

  // control store and step counter
  lrpe_useq u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .status   (status),
    .ctrl     (ctrl)
  );

  // tables, stack and result register
  lrpe_dpath #(
    .NUM_STATES       (NUM_STATES),
    .NUM_TERMINALS    (NUM_TERMINALS),
    .NUM_NONTERMINALS (NUM_NONTERMINALS),
    .NUM_PRODUCTIONS  (NUM_PRODUCTIONS),
    .STACK_DEPTH      (STACK_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .ctrl      (ctrl),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
